// ----- hdl/imhd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Shared types and constants of the indexed min-heap with decrease-key.
// ----------------------------------------------------------------------------
package imhd_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned VtxW        = 10;
  localparam int unsigned DistW       = 31;
  localparam int unsigned LenW        = 11;
  localparam int unsigned AddrW       = 10;

  localparam logic [1:0] OpInit    = 2'd0;
  localparam logic [1:0] OpQueue   = 2'd1;
  localparam logic [1:0] OpDequeue = 2'd2;

  localparam logic [2:0] StDone      = 3'd0;
  localparam logic [2:0] StInserted  = 3'd1;
  localparam logic [2:0] StDecreased = 3'd2;
  localparam logic [2:0] StProcessed = 3'd3;
  localparam logic [2:0] StNotBetter = 3'd4;
  localparam logic [2:0] StError     = 3'd5;

  // Tracker code for a vertex that has been removed from the heap.
  localparam logic [LenW-1:0] TrkProcessed = '1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [VtxW-1:0]  vertex_id;
    logic [DistW-1:0] distance;
  } req_t;

  typedef struct packed {
    logic [VtxW-1:0]  popped_vertex;
    logic [DistW-1:0] popped_distance;
    logic [2:0]       status;
    logic [LenW-1:0]  queue_length;
  } res_t;

  typedef struct packed {
    logic [VtxW-1:0]  vtx;
    logic [DistW-1:0] cost;
  } entry_t;

endpackage
`default_nettype wire

// ----- hdl/imhd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module imhd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/indexed_min_heap_decrease_key_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed min-heap with decrease-key
// Priority queue of (vertex, distance) with a per-vertex position tracker.
// ----------------------------------------------------------------------------
// An operation is taken when start_i is high and busy_o is low; its single
// result appears for one cycle with res_valid_o, and the receiver cannot stall
// it. Heap entries and the tracker live in two registered-read RAMs with one
// read port each, so each level of a sift up passes through SUp and SUpW, and
// each level of a sift down through SDn, SDn1 and SDnX; a decrease first
// reads the old entry in SCmp. The heap holds at most 1024 entries. The
// tracker is cleared by a sweep over all 1024 entries after reset and as
// part of every init, during which busy_o stays high.
module indexed_min_heap_decrease_key_unit (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire imhd_pkg::req_t         req_i,
  output logic                        res_valid_o,
  output imhd_pkg::res_t              res_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [imhd_pkg::VtxW-1:0] cfg_wdata_i
);
  import imhd_pkg::*;

  localparam logic [3:0] SClr  = 4'd0;
  localparam logic [3:0] SIdle = 4'd1;
  localparam logic [3:0] SSeed = 4'd2;
  localparam logic [3:0] STrk  = 4'd3;
  localparam logic [3:0] SCmp  = 4'd4;
  localparam logic [3:0] SPop1 = 4'd5;
  localparam logic [3:0] SPop2 = 4'd6;
  localparam logic [3:0] SUp   = 4'd7;
  localparam logic [3:0] SUpW  = 4'd8;
  localparam logic [3:0] SDn   = 4'd9;
  localparam logic [3:0] SDn1  = 4'd10;
  localparam logic [3:0] SDnX  = 4'd11;

  localparam logic [LenW-1:0]  LenMax  = LenW'(MaxVertices);
  localparam logic [AddrW-1:0] ClrLast = AddrW'(MaxVertices - 1);

  logic [3:0]       state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             init_q, init_d;
  logic [VtxW-1:0]  start_vertex_q;
  logic [1:0]       op_q, op_d;
  logic [VtxW-1:0]  vid_q, vid_d;
  logic [DistW-1:0] dist_q, dist_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [LenW-1:0]  loc_q, loc_d;
  logic [2:0]       stat_q, stat_d;
  logic             single_q, single_d;
  entry_t           cur_q, cur_d;
  entry_t           root_q, root_d;
  entry_t           kid_q, kid_d;

  logic             res_valid_q;
  res_t             res_q, res_d;
  logic             fin;
  logic [2:0]       fin_stat;

  logic             heap_we, heap_re;
  logic [AddrW-1:0] heap_waddr, heap_raddr;
  entry_t           heap_wdata, heap_rdata;
  logic             trk_we, trk_re;
  logic [AddrW-1:0] trk_waddr, trk_raddr;
  logic [LenW-1:0]  trk_wdata, trk_rdata;

  logic [LenW:0]    kid_pos;
  logic [LenW:0]    kid_pos1;
  entry_t           pick;
  logic [LenW:0]    pick_pos;

  imhd_ram #(.Width($bits(entry_t)), .Depth(MaxVertices)) u_heap (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .re_i    (heap_re),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  imhd_ram #(.Width(LenW), .Depth(MaxVertices)) u_trk (
    .clk_i   (clk_i),
    .we_i    (trk_we),
    .waddr_i (trk_waddr),
    .wdata_i (trk_wdata),
    .re_i    (trk_re),
    .raddr_i (trk_raddr),
    .rdata_o (trk_rdata)
  );

  assign kid_pos  = {pos_q, 1'b0};
  assign kid_pos1 = kid_pos + (LenW+1)'(1);

  always_comb begin
    if (single_q || (kid_q.cost < heap_rdata.cost)) begin
      pick     = kid_q;
      pick_pos = kid_pos;
    end else begin
      pick     = heap_rdata;
      pick_pos = kid_pos1;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    init_d     = init_q;
    op_d       = op_q;
    vid_d      = vid_q;
    dist_d     = dist_q;
    len_d      = len_q;
    pos_d      = pos_q;
    loc_d      = loc_q;
    stat_d     = stat_q;
    single_d   = single_q;
    cur_d      = cur_q;
    root_d     = root_q;
    kid_d      = kid_q;
    fin        = 1'b0;
    fin_stat   = stat_q;
    heap_we    = 1'b0;
    heap_waddr = AddrW'(pos_q - LenW'(1));
    heap_wdata = cur_q;
    heap_re    = 1'b0;
    heap_raddr = '0;
    trk_we     = 1'b0;
    trk_waddr  = cur_q.vtx;
    trk_wdata  = pos_q;
    trk_re     = 1'b0;
    trk_raddr  = req_i.vertex_id;

    case (state_q)
      SClr: begin
        trk_we    = 1'b1;
        trk_waddr = clr_cnt_q;
        trk_wdata = '0;
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == ClrLast) begin
          state_d = init_q ? SSeed : SIdle;
          init_d  = 1'b0;
        end
      end
      SIdle: begin
        if (start_i) begin
          op_d   = req_i.operation;
          vid_d  = req_i.vertex_id;
          dist_d = req_i.distance;
          case (req_i.operation)
            OpInit: begin
              init_d    = 1'b1;
              clr_cnt_d = '0;
              len_d     = '0;
              state_d   = SClr;
            end
            OpQueue: begin
              trk_re  = 1'b1;
              state_d = STrk;
            end
            OpDequeue: begin
              if (len_q == '0) begin
                fin      = 1'b1;
                fin_stat = StError;
              end else begin
                heap_re    = 1'b1;
                heap_raddr = '0;
                state_d    = SPop1;
              end
            end
            default: begin
              fin      = 1'b1;
              fin_stat = StError;
            end
          endcase
        end
      end
      SSeed: begin
        heap_we    = 1'b1;
        heap_waddr = '0;
        heap_wdata = '{vtx: start_vertex_q, cost: '0};
        trk_we     = 1'b1;
        trk_waddr  = start_vertex_q;
        trk_wdata  = LenW'(1);
        len_d      = LenW'(1);
        fin        = 1'b1;
        fin_stat   = StDone;
        state_d    = SIdle;
      end
      STrk: begin
        if (trk_rdata == TrkProcessed) begin
          fin      = 1'b1;
          fin_stat = StProcessed;
          state_d  = SIdle;
        end else if (trk_rdata == '0) begin
          if (len_q == LenMax) begin
            fin      = 1'b1;
            fin_stat = StError;
            state_d  = SIdle;
          end else begin
            len_d   = len_q + LenW'(1);
            pos_d   = len_q + LenW'(1);
            cur_d   = '{vtx: vid_q, cost: dist_q};
            stat_d  = StInserted;
            state_d = SUp;
          end
        end else if (trk_rdata > len_q) begin
          fin      = 1'b1;
          fin_stat = StError;
          state_d  = SIdle;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = AddrW'(trk_rdata - LenW'(1));
          loc_d      = trk_rdata;
          state_d    = SCmp;
        end
      end
      SCmp: begin
        if (heap_rdata.cost > dist_q) begin
          cur_d   = '{vtx: vid_q, cost: dist_q};
          pos_d   = loc_q;
          stat_d  = StDecreased;
          state_d = SUp;
        end else begin
          fin      = 1'b1;
          fin_stat = StNotBetter;
          state_d  = SIdle;
        end
      end
      SPop1: begin
        root_d     = heap_rdata;
        heap_re    = 1'b1;
        heap_raddr = AddrW'(len_q - LenW'(1));
        state_d    = SPop2;
      end
      SPop2: begin
        cur_d     = heap_rdata;
        trk_we    = 1'b1;
        trk_waddr = root_q.vtx;
        trk_wdata = TrkProcessed;
        len_d     = len_q - LenW'(1);
        pos_d     = LenW'(1);
        stat_d    = StDone;
        if (len_q == LenW'(1)) begin
          fin      = 1'b1;
          fin_stat = StDone;
          state_d  = SIdle;
        end else begin
          state_d = SDn;
        end
      end
      SUp: begin
        if (pos_q == LenW'(1)) begin
          heap_we  = 1'b1;
          trk_we   = 1'b1;
          fin      = 1'b1;
          state_d  = SIdle;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = AddrW'((pos_q >> 1) - LenW'(1));
          state_d    = SUpW;
        end
      end
      SUpW: begin
        heap_we = 1'b1;
        trk_we  = 1'b1;
        if (cur_q.cost < heap_rdata.cost) begin
          // Parent moves down into the hole; the held entry keeps rising.
          heap_wdata = heap_rdata;
          trk_waddr  = heap_rdata.vtx;
          pos_d      = pos_q >> 1;
          state_d    = SUp;
        end else begin
          fin     = 1'b1;
          state_d = SIdle;
        end
      end
      SDn: begin
        if (kid_pos > {1'b0, len_q}) begin
          heap_we = 1'b1;
          trk_we  = 1'b1;
          fin     = 1'b1;
          state_d = SIdle;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = AddrW'(kid_pos - (LenW+1)'(1));
          state_d    = SDn1;
        end
      end
      SDn1: begin
        kid_d = heap_rdata;
        if (kid_pos1 > {1'b0, len_q}) begin
          single_d = 1'b1;
        end else begin
          single_d   = 1'b0;
          heap_re    = 1'b1;
          heap_raddr = AddrW'(kid_pos);
        end
        state_d = SDnX;
      end
      SDnX: begin
        heap_we = 1'b1;
        trk_we  = 1'b1;
        if (cur_q.cost > pick.cost) begin
          heap_wdata = pick;
          trk_waddr  = pick.vtx;
          pos_d      = LenW'(pick_pos);
          state_d    = SDn;
        end else begin
          fin     = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    res_d = res_q;
    if (fin) begin
      res_d.status       = fin_stat;
      res_d.queue_length = len_d;
      if (op_d == OpDequeue && fin_stat == StDone) begin
        res_d.popped_vertex   = (state_q == SIdle) ? '0 : root_d.vtx;
        res_d.popped_distance = (state_q == SIdle) ? '0 : root_d.cost;
      end else begin
        res_d.popped_vertex   = '0;
        res_d.popped_distance = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SClr;
      clr_cnt_q      <= '0;
      init_q         <= 1'b0;
      len_q          <= '0;
      res_valid_q    <= 1'b0;
      start_vertex_q <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      init_q      <= init_d;
      len_q       <= len_d;
      res_valid_q <= fin;
      if (cfg_we_i) begin
        start_vertex_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    vid_q    <= vid_d;
    dist_q   <= dist_d;
    pos_q    <= pos_d;
    loc_q    <= loc_d;
    stat_q   <= stat_d;
    single_q <= single_d;
    cur_q    <= cur_d;
    root_q   <= root_d;
    kid_q    <= kid_d;
    res_q    <= res_d;
  end

  assign busy_o      = (state_q != SIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A result always leaves the engine back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (state_q == SIdle))
    else $error("result strobe while an operation is still running");

  // The heap never holds more entries than there are vertices.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("heap length beyond capacity");

  // Nothing is written into the heap while the engine is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> !heap_we)
    else $error("heap write while idle");

  // The length moves by at most one per cycle, apart from init.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle && state_q != SSeed) |=>
      (len_q == $past(len_q) || len_q == $past(len_q) + LenW'(1)
       || len_q == $past(len_q) - LenW'(1)))
    else $error("heap length jumped");

endmodule
`default_nettype wire

// ----- tb/indexed_min_heap_decrease_key_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed min-heap with decrease-key testbench
// Drives init, queue and dequeue operations with random gaps and rewrites the
// start vertex between phases. A scoreboard mirrors the heap and the vertex
// tracker and checks every result field against its own prediction.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_unit_tb;
  import imhd_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [DistW-1:0] DistMax = '1;

  class heap_scoreboard;
    logic [VtxW-1:0]  ent_vtx[1:MaxVertices];
    logic [DistW-1:0] ent_dist[1:MaxVertices];
    logic [LenW-1:0]  tracker[0:MaxVertices-1];
    int unsigned      length;
    logic [VtxW-1:0]  start_vtx;
    res_t             pending[$];
    int               errors;

    function new();
      for (int i = 0; i < MaxVertices; i++) tracker[i] = '0;
      length = 0;
      start_vtx = '0;
      errors = 0;
    endfunction

    function void swap_entries(int unsigned p, int unsigned q);
      logic [VtxW-1:0]  tv;
      logic [DistW-1:0] td;
      tv = ent_vtx[p];  td = ent_dist[p];
      ent_vtx[p] = ent_vtx[q];  ent_dist[p] = ent_dist[q];
      ent_vtx[q] = tv;  ent_dist[q] = td;
      tracker[ent_vtx[p]] = p[LenW-1:0];
      tracker[ent_vtx[q]] = q[LenW-1:0];
    endfunction

    function void bubble_up(int unsigned pos);
      while (pos > 1 && ent_dist[pos] < ent_dist[pos >> 1]) begin
        swap_entries(pos, pos >> 1);
        pos = pos >> 1;
      end
    endfunction

    function void bubble_down(int unsigned pos);
      int unsigned kid, pick;
      forever begin
        kid = pos << 1;
        if (kid > length) break;
        // The right child wins a tie.
        if (kid + 1 > length || ent_dist[kid] < ent_dist[kid + 1]) pick = kid;
        else pick = kid + 1;
        if (ent_dist[pos] > ent_dist[pick]) begin
          swap_entries(pos, pick);
          pos = pick;
        end else begin
          break;
        end
      end
    endfunction

    function void note_request(req_t r);
      res_t        e;
      int unsigned loc;
      e = '0;
      e.status = StError;
      case (r.operation)
        OpInit: begin
          for (int i = 0; i < MaxVertices; i++) tracker[i] = '0;
          ent_vtx[1] = start_vtx;
          ent_dist[1] = '0;
          tracker[start_vtx] = LenW'(1);
          length = 1;
          e.status = StDone;
        end
        OpQueue: begin
          loc = tracker[r.vertex_id];
          if (tracker[r.vertex_id] == TrkProcessed) begin
            e.status = StProcessed;
          end else if (loc == 0) begin
            if (length < MaxVertices) begin
              length++;
              ent_vtx[length] = r.vertex_id;
              ent_dist[length] = r.distance;
              tracker[r.vertex_id] = length[LenW-1:0];
              bubble_up(length);
              e.status = StInserted;
            end
          end else if (loc <= length) begin
            if (ent_dist[loc] > r.distance) begin
              ent_dist[loc] = r.distance;
              bubble_up(loc);
              e.status = StDecreased;
            end else begin
              e.status = StNotBetter;
            end
          end
        end
        OpDequeue: begin
          if (length > 0) begin
            e.popped_vertex = ent_vtx[1];
            e.popped_distance = ent_dist[1];
            tracker[ent_vtx[1]] = TrkProcessed;
            ent_vtx[1] = ent_vtx[length];
            ent_dist[1] = ent_dist[length];
            length--;
            if (length > 0) begin
              tracker[ent_vtx[1]] = LenW'(1);
              bubble_down(1);
            end
            e.status = StDone;
          end
        end
        default: ;
      endcase
      e.queue_length = length[LenW-1:0];
      pending.push_back(e);
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.popped_vertex !== e.popped_vertex) begin
        $display("%0t: popped_vertex expected %0d actual %0d", $time,
                 e.popped_vertex, a.popped_vertex);
        errors++;
      end
      if (a.popped_distance !== e.popped_distance) begin
        $display("%0t: popped_distance expected %0d actual %0d", $time,
                 e.popped_distance, a.popped_distance);
        errors++;
      end
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.queue_length !== e.queue_length) begin
        $display("%0t: queue_length expected %0d actual %0d", $time,
                 e.queue_length, a.queue_length);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start_i = 1'b0;
  logic            busy_o;
  req_t            req_i = '0;
  logic            res_valid_o;
  res_t            res_o;
  logic            cfg_we_i = 1'b0;
  logic [VtxW-1:0] cfg_wdata_i = '0;

  heap_scoreboard sb = new();
  bit             no_idle;

  indexed_min_heap_decrease_key_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_o);
  end

  // Leaves start high so that back-to-back transfers need no second assignment.
  task automatic issue_op(logic [1:0] op, logic [VtxW-1:0] v, logic [DistW-1:0] d);
    req_t r;
    r.operation = op;
    r.vertex_id = v;
    r.distance = d;
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(r);
  endtask

  task automatic idle_gap();
    int unsigned sel, n;
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 50) n = 0;
    else if (sel < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic write_start_vertex(logic [VtxW-1:0] v);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.start_vtx = v;
  endtask

  task automatic random_op();
    int unsigned     sel;
    logic [VtxW-1:0]  v;
    logic [DistW-1:0] d;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 7) v = VtxW'($urandom_range(0, 31));
    else v = VtxW'($urandom());
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = DistMax;
      2: d = DistW'($urandom());
      default: d = DistW'($urandom_range(0, 1000));
    endcase
    if (sel < 57) issue_op(OpQueue, v, d);
    else if (sel < 94) issue_op(OpDequeue, v, d);
    else if (sel < 97) issue_op(OpUnused, v, d);
    else issue_op(OpInit, v, d);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before any init the heap is empty but still takes inserts.
    no_idle = 1'b0;
    issue_op(OpQueue, 10'd5, 31'd100);    idle_gap();
    issue_op(OpDequeue, '0, '0);          idle_gap();
    issue_op(OpDequeue, '0, '0);          idle_gap();
    issue_op(OpUnused, '1, DistMax);      idle_gap();
    write_start_vertex('1);
    issue_op(OpInit, '0, '0);             idle_gap();
    issue_op(OpQueue, 10'd0, DistMax);    idle_gap();
    issue_op(OpQueue, '1, DistMax);       idle_gap();
    issue_op(OpQueue, 10'd7, 31'd50);     idle_gap();
    issue_op(OpQueue, 10'd7, 31'd60);     idle_gap();
    issue_op(OpQueue, 10'd7, 31'd50);     idle_gap();
    issue_op(OpQueue, 10'd7, 31'd10);     idle_gap();
    issue_op(OpQueue, 10'd0, 31'd0);      idle_gap();
    issue_op(OpDequeue, '0, '0);          idle_gap();
    issue_op(OpDequeue, '0, '0);          idle_gap();
    issue_op(OpQueue, '1, 31'd0);         idle_gap();
    issue_op(OpQueue, 10'h2AA, 31'h2AAAAAAA); idle_gap();
    issue_op(OpQueue, 10'h155, 31'h55555555); idle_gap();
    issue_op(OpQueue, 10'd9, 31'h55555555);   idle_gap();
    issue_op(OpQueue, 10'd11, 31'h55555555);  idle_gap();
    issue_op(OpDequeue, '0, '0);          idle_gap();
    issue_op(OpDequeue, '0, '0);          idle_gap();
    issue_op(OpDequeue, '0, '0);          idle_gap();
    write_start_vertex('0);
    issue_op(OpInit, '0, '0);             idle_gap();

    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 15) write_start_vertex('1);
      else if (ph == 7) write_start_vertex('0);
      else write_start_vertex(VtxW'($urandom()));
      no_idle = ($urandom_range(0, 3) == 0);
      issue_op(OpInit, VtxW'($urandom()), DistW'($urandom()));
      idle_gap();
      repeat (38) begin
        random_op();
        idle_gap();
      end
    end

    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) $display("indexed_min_heap_decrease_key_unit_tb: done, clean");
    else $display("indexed_min_heap_decrease_key_unit_tb: done, errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("indexed_min_heap_decrease_key_unit_tb: done, errors");
    $finish;
  end

endmodule
